// ===== rtl/password_lock_controller_macros.svh =====
// Assertion macros for the password lock controller checks.
`ifndef PASSWORD_LOCK_CONTROLLER_MACROS_SVH
`define PASSWORD_LOCK_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define PLC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("password lock controller check failed");

// Next-cycle implication, disabled while rst is high.
`define PLC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("password lock controller check failed");

`endif

// ===== rtl/plc_pkg.sv =====
// Types and constants shared by the password lock controller files.
`default_nettype none
package plc_pkg;

   localparam int BYTE_W     = 8;
   localparam int TICK_W     = 10;
   localparam int FAIL_W     = 4;
   localparam int CODE_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // Register reset values
   localparam logic [FAIL_W-1:0] MAX_FAILURES_RST = 4'd3;
   localparam logic [TICK_W-1:0] OPEN_TICKS_RST   = 10'd480;
   localparam logic [TICK_W-1:0] HOLD_TICKS_RST   = 10'd92;
   localparam logic [TICK_W-1:0] ALARM_TICKS_RST  = 10'd8;

   // Link bytes with a meaning of their own
   localparam logic [BYTE_W-1:0] READY_BYTE = 8'd7;
   localparam logic [BYTE_W-1:0] OPT_CHANGE = 8'd0;
   localparam logic [BYTE_W-1:0] OPT_OPEN   = 8'd1;

   // Request kinds
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [3:0] {
      PH_WAIT_READY,
      PH_SET_FIRST,
      PH_SET_SECOND,
      PH_CHECK,
      PH_OPTION,
      PH_OPENING,
      PH_HOLD,
      PH_CLOSING,
      PH_ALARM
   } phase_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_NOMATCH = 4'd0,
      CODE_MATCH   = 4'd1,
      CODE_OPEN    = 4'd2,
      CODE_BUZZER  = 4'd3,
      CODE_ENTER   = 4'd4,
      CODE_REPEAT  = 4'd5,
      CODE_OPTION  = 4'd6,
      CODE_DONE    = 4'd8
   } code_type;

   typedef enum logic [1:0] {
      MOTOR_OFF = 2'd0,
      MOTOR_CW  = 2'd1,
      MOTOR_ACW = 2'd2
   } motor_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_FAILURES = 2'd0,
      CSR_OPEN_TICKS   = 2'd1,
      CSR_HOLD_TICKS   = 2'd2,
      CSR_ALARM_TICKS  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [FAIL_W-1:0] max_failures;
      logic [TICK_W-1:0] open_ticks;
      logic [TICK_W-1:0] hold_ticks;
      logic [TICK_W-1:0] alarm_ticks;
   } cfg_type;

   typedef struct packed {
      code_type  tx_code;
      motor_type motor_drive;
      logic      buzzer;
      logic      last;
   } rsp_item_type;

   // Up to two results per request go into the queue in one cycle
   typedef struct packed {
      logic         valid0;
      logic         valid1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage
`default_nettype wire

// ===== rtl/plc_if.sv =====
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface plc_req_if;
   import plc_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, cmd, rx_byte, input ready);
   modport sink (input valid, cmd, rx_byte, output ready);
endinterface

interface plc_rsp_if;
   import plc_pkg::*;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] tx_code;
   logic [1:0]        motor_drive;
   logic              buzzer;
   logic              last;
   modport source (output valid, tx_code, motor_drive, buzzer, last, input ready);
   modport sink (input valid, tx_code, motor_drive, buzzer, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/plc_rsp_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one.
`default_nettype none
module plc_rsp_fifo #(
   parameter int DEPTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  plc_pkg::push_type            push,
   input  logic                         pop,
   output plc_pkg::rsp_item_type        head,
   output logic                         not_empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   import plc_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rsp_item_type    store_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   wr_ptr_nxt;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_ptr_nxt = wrap_inc(wr_ptr_ff);

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.valid0 && push.valid1) begin
         wr_ptr_in = wrap_inc(wr_ptr_nxt);
      end else if (push.valid0) begin
         wr_ptr_in = wr_ptr_nxt;
      end
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.valid0) + CW'(push.valid1) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage writes; second result lands right after the first
   always_ff @(posedge clock) begin
      if (push.valid0) begin
         store_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.valid0 && push.valid1) begin
         store_ff[wr_ptr_nxt] <= push.item1;
      end
   end

   assign head      = store_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule
`default_nettype wire

// ===== rtl/plc_core.sv =====
// Lock state machine: one registered request in, up to two results out.
`default_nettype none
module plc_core #(
   parameter int PASSWORD_LEN = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        in_cmd,
   input  logic [plc_pkg::BYTE_W-1:0]  in_byte,
   input  plc_pkg::cfg_type            cfg,
   output plc_pkg::push_type           push
);
   import plc_pkg::*;

   localparam int PW = $clog2(PASSWORD_LEN + 1);
   localparam int IW = (PASSWORD_LEN > 1) ? $clog2(PASSWORD_LEN) : 1;

   phase_type          phase_ff, phase_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic               mis_ff, mis_in;
   logic [FAIL_W-1:0]  fail_ff, fail_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic               first_ff, first_in;
   motor_type          motor_ff, motor_in;
   logic               buzz_ff, buzz_in;

   // Password stores, written one byte per request
   logic [BYTE_W-1:0]  entry_buf_ff [PASSWORD_LEN];
   logic [BYTE_W-1:0]  saved_pw_ff  [PASSWORD_LEN];

   logic               is_byte, is_tick;
   logic [IW-1:0]      idx;
   logic               pos_last;
   logic [PW-1:0]      pos_inc;
   logic [BYTE_W-1:0]  cmp_byte;
   logic               mis_any;
   logic [FAIL_W-1:0]  fail_inc;
   logic               lockout;
   logic [TICK_W-1:0]  tick_limit, tick_inc;
   logic               tick_hit;

   assign is_byte  = in_valid && (in_cmd == CMD_BYTE);
   assign is_tick  = in_valid && (in_cmd == CMD_TICK);
   assign idx      = pos_ff[IW-1:0];
   assign pos_last = (pos_ff == PW'(PASSWORD_LEN - 1));
   assign pos_inc  = pos_ff + 1'b1;

   // Compare against the first entry while setting, the saved one while checking
   assign cmp_byte = (phase_ff == PH_CHECK) ? saved_pw_ff[idx] : entry_buf_ff[idx];
   assign mis_any  = mis_ff || (cmp_byte != in_byte);

   assign fail_inc = fail_ff + 1'b1;
   assign lockout  = (fail_inc >= cfg.max_failures) || (fail_inc == '0);

   // Tick limit of the timed phase in progress
   always_comb begin
      case (phase_ff)
         PH_OPENING, PH_CLOSING: tick_limit = cfg.open_ticks;
         PH_HOLD:                tick_limit = cfg.hold_ticks;
         default:                tick_limit = cfg.alarm_ticks;
      endcase
   end
   assign tick_inc = tick_ff + 1'b1;
   assign tick_hit = (tick_inc >= tick_limit) || (tick_inc == '0);

   // Next state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      mis_in   = mis_ff;
      fail_in  = fail_ff;
      tick_in  = tick_ff;
      first_in = first_ff;
      motor_in = motor_ff;
      buzz_in  = buzz_ff;
      case (phase_ff)
         PH_WAIT_READY: begin
            if (is_byte && (in_byte == READY_BYTE)) begin
               phase_in = PH_SET_FIRST;
               pos_in   = '0;
               mis_in   = 1'b0;
            end
         end
         PH_SET_FIRST: begin
            if (is_byte) begin
               pos_in = pos_inc;
               if (pos_last) begin
                  phase_in = PH_SET_SECOND;
                  pos_in   = '0;
                  mis_in   = 1'b0;
               end
            end
         end
         PH_SET_SECOND: begin
            if (is_byte) begin
               pos_in = pos_inc;
               mis_in = mis_any;
               if (pos_last) begin
                  pos_in = '0;
                  mis_in = 1'b0;
                  if (mis_any) begin
                     phase_in = PH_SET_FIRST;
                  end else if (first_ff) begin
                     first_in = 1'b0;
                     phase_in = PH_CHECK;
                  end else begin
                     phase_in = PH_OPTION;
                     pos_in   = pos_inc;
                     mis_in   = mis_any;
                  end
               end
            end
         end
         PH_CHECK: begin
            if (is_byte) begin
               pos_in = pos_inc;
               mis_in = mis_any;
               if (pos_last) begin
                  if (!mis_any) begin
                     fail_in  = '0;
                     phase_in = PH_OPTION;
                  end else if (lockout) begin
                     fail_in  = '0;
                     tick_in  = '0;
                     buzz_in  = 1'b1;
                     phase_in = PH_ALARM;
                  end else begin
                     fail_in  = fail_inc;
                     phase_in = PH_CHECK;
                     pos_in   = '0;
                     mis_in   = 1'b0;
                  end
               end
            end
         end
         PH_OPTION: begin
            if (is_byte) begin
               if (in_byte == OPT_CHANGE) begin
                  phase_in = PH_SET_FIRST;
                  pos_in   = '0;
                  mis_in   = 1'b0;
               end else if (in_byte == OPT_OPEN) begin
                  tick_in  = '0;
                  motor_in = MOTOR_CW;
                  phase_in = PH_OPENING;
               end
            end
         end
         PH_OPENING, PH_HOLD, PH_CLOSING, PH_ALARM: begin
            if (is_tick) begin
               tick_in = tick_hit ? '0 : tick_inc;
               if (tick_hit) begin
                  case (phase_ff)
                     PH_OPENING: begin
                        motor_in = MOTOR_OFF;
                        phase_in = PH_HOLD;
                     end
                     PH_HOLD: begin
                        motor_in = MOTOR_ACW;
                        phase_in = PH_CLOSING;
                     end
                     PH_CLOSING: begin
                        motor_in = MOTOR_OFF;
                        phase_in = PH_OPTION;
                     end
                     default: begin
                        buzz_in  = 1'b0;
                        phase_in = PH_CHECK;
                        pos_in   = '0;
                        mis_in   = 1'b0;
                     end
                  endcase
               end
            end
         end
         default: ;
      endcase
   end

   // Results; levels shown are those after the update, but for the check phase's first buzzer level
   always_comb begin
      push = '0;
      push.item0.motor_drive = motor_in;
      push.item0.buzzer      = buzz_in;
      push.item1.motor_drive = motor_in;
      push.item1.buzzer      = buzz_in;
      push.item0.tx_code     = CODE_ENTER;
      push.item1.tx_code     = CODE_ENTER;
      case (phase_ff)
         PH_WAIT_READY: begin
            push.valid0 = is_byte && (in_byte == READY_BYTE);
         end
         PH_SET_FIRST: begin
            push.valid0        = is_byte && pos_last;
            push.item0.tx_code = CODE_REPEAT;
         end
         PH_SET_SECOND: begin
            push.valid0 = is_byte && pos_last;
            push.valid1 = is_byte && pos_last;
            if (mis_any) begin
               push.item0.tx_code = CODE_NOMATCH;
            end else begin
               push.item0.tx_code = CODE_MATCH;
               push.item1.tx_code = first_ff ? CODE_ENTER : CODE_OPTION;
            end
         end
         PH_CHECK: begin
            push.valid0 = is_byte && pos_last;
            push.valid1 = is_byte && pos_last;
            push.item0.buzzer = buzz_ff;
            if (!mis_any) begin
               push.item0.tx_code = CODE_MATCH;
               push.item1.tx_code = CODE_OPTION;
            end else begin
               push.item0.tx_code = CODE_NOMATCH;
               push.item1.tx_code = lockout ? CODE_BUZZER : CODE_ENTER;
            end
         end
         PH_OPTION: begin
            push.valid0 = is_byte;
            if (in_byte == OPT_CHANGE) begin
               push.item0.tx_code = CODE_ENTER;
            end else if (in_byte == OPT_OPEN) begin
               push.item0.tx_code = CODE_OPEN;
            end else begin
               push.item0.tx_code = CODE_OPTION;
            end
         end
         PH_OPENING, PH_HOLD: begin
            push.valid0        = is_tick && tick_hit;
            push.item0.tx_code = CODE_DONE;
         end
         PH_CLOSING: begin
            push.valid0        = is_tick && tick_hit;
            push.item0.tx_code = CODE_OPTION;
         end
         PH_ALARM: begin
            push.valid0        = is_tick && tick_hit;
            push.valid1        = is_tick && tick_hit;
            push.item0.tx_code = CODE_DONE;
         end
         default: ;
      endcase
      push.item0.last = !push.valid1;
      push.item1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_READY;
         pos_ff   <= '0;
         mis_ff   <= 1'b0;
         fail_ff  <= '0;
         tick_ff  <= '0;
         first_ff <= 1'b1;
         motor_ff <= MOTOR_OFF;
         buzz_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         mis_ff   <= mis_in;
         fail_ff  <= fail_in;
         tick_ff  <= tick_in;
         first_ff <= first_in;
         motor_ff <= motor_in;
         buzz_ff  <= buzz_in;
      end
   end

   // The second entry goes straight into the saved store; nothing reads
   // that store until a second entry has matched the first in full.
   always_ff @(posedge clock) begin
      if (is_byte && (phase_ff == PH_SET_FIRST)) begin
         entry_buf_ff[idx] <= in_byte;
      end
      if (is_byte && (phase_ff == PH_SET_SECOND)) begin
         saved_pw_ff[idx] <= in_byte;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/password_lock_controller.sv =====
// Password lock controller: a request is a link byte or a timer tick. It
// takes one request per clock while its result queue has room; a request's
// results (at most two, the final one marked by last) pass through the
// request register and then the result queue before the result channel.
// The result queue holds RSP_DEPTH entries, and req ready drops while more
// than RSP_DEPTH-4 of them are in use, so a slow result consumer throttles
// the request side. The user must write registers through the csr port only
// while no request is in flight; the block itself does not enforce this.
`default_nettype none
module password_lock_controller #(
   parameter int PASSWORD_LEN = 5,
   parameter int RSP_DEPTH    = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   plc_req_if.sink                           req_if,
   plc_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [plc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [plc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import plc_pkg::*;

   localparam int CW = $clog2(RSP_DEPTH + 1);

   cfg_type            cfg_ff, cfg_in;
   logic               in_valid_ff, in_valid_in;
   logic               in_cmd_ff;
   logic [BYTE_W-1:0]  in_byte_ff;
   push_type           push;
   rsp_item_type       head;
   logic               not_empty;
   logic [CW-1:0]      fifo_count;
   logic               pop;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_FAILURES: cfg_in.max_failures = csr_wdata[FAIL_W-1:0];
            CSR_OPEN_TICKS:   cfg_in.open_ticks   = csr_wdata[TICK_W-1:0];
            CSR_HOLD_TICKS:   cfg_in.hold_ticks   = csr_wdata[TICK_W-1:0];
            CSR_ALARM_TICKS:  cfg_in.alarm_ticks  = csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_failures <= MAX_FAILURES_RST;
         cfg_ff.open_ticks   <= OPEN_TICKS_RST;
         cfg_ff.hold_ticks   <= HOLD_TICKS_RST;
         cfg_ff.alarm_ticks  <= ALARM_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request register; room for the in-flight and the new request's results
   assign req_if.ready = (fifo_count <= CW'(RSP_DEPTH - 4));
   assign in_valid_in  = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_cmd_ff  <= req_if.cmd;
         in_byte_ff <= req_if.rx_byte;
      end
   end

   plc_core #(
      .PASSWORD_LEN (PASSWORD_LEN)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_cmd   (in_cmd_ff),
      .in_byte  (in_byte_ff),
      .cfg      (cfg_ff),
      .push     (push)
   );

   plc_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .count     (fifo_count)
   );

   // Result channel straight from the queue head
   assign pop                = not_empty && rsp_if.ready;
   assign rsp_if.valid       = not_empty;
   assign rsp_if.tx_code     = head.tx_code;
   assign rsp_if.motor_drive = head.motor_drive;
   assign rsp_if.buzzer      = head.buzzer;
   assign rsp_if.last        = head.last;

endmodule
`default_nettype wire

// ===== rtl/plc_checker.sv =====
// Port-level checks for the password lock controller and their binding.
`default_nettype none
`include "password_lock_controller_macros.svh"
module plc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] tx_code,
   input logic [1:0] motor_drive
);
   import plc_pkg::*;

   // A pending result is never withdrawn
   `PLC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // Reset empties the queue and reopens the request side
   `PLC_ASSERT_NXT(a_rst_clear, clock, 1'b0, reset, !rsp_valid && req_ready)
   // Only protocol codes leave the block
   `PLC_ASSERT_IMP(a_code_ok, clock, reset, rsp_valid, (tx_code <= CODE_OPTION) || (tx_code == CODE_DONE))
   // The motor has three drive states only
   `PLC_ASSERT_IMP(a_motor_ok, clock, reset, rsp_valid, motor_drive <= MOTOR_ACW)

endmodule

bind password_lock_controller plc_checker u_plc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .tx_code     (rsp_if.tx_code),
   .motor_drive (rsp_if.motor_drive)
);
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the password lock controller: directed table, then random traffic.
`timescale 1ns / 1ps
module testbench;
   import plc_pkg::*;

   localparam int PW_LEN     = 5;
   localparam int IDLE_LIMIT = 400;
   localparam int SETTLE     = 6;

   // One directed request; n < 0 means the answer comes from the lock model
   typedef struct {
      logic              cmd;
      logic [BYTE_W-1:0] data;
      int                n;
      code_type          c0;
      motor_type         m0;
      logic              b0;
      code_type          c1;
      motor_type         m1;
      logic              b1;
   } step_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   plc_req_if req_ch ();
   plc_rsp_if rsp_ch ();

   password_lock_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Lock model state
   cfg_type           cfg;
   phase_type         lock_phase;
   logic [BYTE_W-1:0] entry_buf [PW_LEN];
   logic [BYTE_W-1:0] saved_pw [PW_LEN];
   logic [2:0]        entry_pos;
   bit                entry_bad;
   logic [FAIL_W-1:0] fail_cnt;
   logic [TICK_W-1:0] tick_cnt;
   bit                first_pw;
   motor_type         motor;
   logic              buzz;

   rsp_item_type step_replies [$];
   rsp_item_type awaited_replies [$];
   bit           step_used;
   bit           honest_entry;
   bit           req_steady;
   bit           rsp_steady;
   rsp_item_type want;
   rsp_item_type got;

   int errors         = 0;
   int requests_sent  = 0;
   int requests_used  = 0;
   int replies_seen   = 0;
   int settings_run   = 0;
   int idle_cycles    = 0;

   // Directed table, run with max_failures 0, open 0, hold 1, alarm 0
   step_row_type dir_rows [34] = '{
      '{CMD_TICK, 8'h00, 0, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'hFF, 0, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, READY_BYTE, 1, CODE_ENTER, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h00, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_TICK, 8'hA5, 0, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'hFF, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h80, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h01, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h7F, 1, CODE_REPEAT, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h00, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'hFF, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h80, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h01, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h7F, 2, CODE_MATCH, MOTOR_OFF, 1'b0, CODE_ENTER, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h00, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'hFF, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h80, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h01, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'hFE, 2, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_BUZZER, MOTOR_OFF, 1'b1},
      '{CMD_BYTE, READY_BYTE, 0, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_TICK, 8'h00, 2, CODE_DONE, MOTOR_OFF, 1'b0, CODE_ENTER, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h00, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'hFF, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h80, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h01, -1, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h7F, 2, CODE_MATCH, MOTOR_OFF, 1'b0, CODE_OPTION, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'h2A, 1, CODE_OPTION, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_TICK, 8'h00, 0, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, OPT_OPEN, 1, CODE_OPEN, MOTOR_CW, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, 8'hFF, 0, CODE_NOMATCH, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_TICK, 8'h00, 1, CODE_DONE, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_TICK, 8'h00, 1, CODE_DONE, MOTOR_ACW, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_TICK, 8'h00, 1, CODE_OPTION, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0},
      '{CMD_BYTE, OPT_CHANGE, 1, CODE_ENTER, MOTOR_OFF, 1'b0, CODE_NOMATCH, MOTOR_OFF, 1'b0}
   };

   // ---------------------------------------------------------------- lock model

   function automatic void lock_reset();
      cfg        = '{MAX_FAILURES_RST, OPEN_TICKS_RST, HOLD_TICKS_RST, ALARM_TICKS_RST};
      lock_phase = PH_WAIT_READY;
      foreach (entry_buf[k]) begin
         entry_buf[k] = '0;
         saved_pw[k]  = '0;
      end
      entry_pos = '0;
      entry_bad = 1'b0;
      fail_cnt  = '0;
      tick_cnt  = '0;
      first_pw  = 1'b1;
      motor     = MOTOR_OFF;
      buzz      = 1'b0;
   endfunction

   function automatic void note(code_type c);
      step_replies.push_back('{tx_code: c, motor_drive: motor, buzzer: buzz, last: 1'b0});
   endfunction

   function automatic void begin_entry(phase_type p);
      lock_phase = p;
      entry_pos  = '0;
      entry_bad  = 1'b0;
   endfunction

   // Counts a tick; true when the limit is reached, zero limit ends at once
   function automatic bit tick_elapsed(logic [TICK_W-1:0] limit);
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= limit || tick_cnt == '0) begin
         tick_cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advances the lock by one request, leaving its answers in step_replies
   function automatic void advance_lock(logic cmd, logic [BYTE_W-1:0] data);
      step_replies.delete();
      step_used = 1'b0;
      if (cmd == CMD_TICK) begin
         case (lock_phase)
            PH_OPENING: begin
               step_used = 1'b1;
               if (tick_elapsed(cfg.open_ticks)) begin
                  motor      = MOTOR_OFF;
                  lock_phase = PH_HOLD;
                  note(CODE_DONE);
               end
            end
            PH_HOLD: begin
               step_used = 1'b1;
               if (tick_elapsed(cfg.hold_ticks)) begin
                  motor      = MOTOR_ACW;
                  lock_phase = PH_CLOSING;
                  note(CODE_DONE);
               end
            end
            PH_CLOSING: begin
               step_used = 1'b1;
               if (tick_elapsed(cfg.open_ticks)) begin
                  motor      = MOTOR_OFF;
                  lock_phase = PH_OPTION;
                  note(CODE_OPTION);
               end
            end
            PH_ALARM: begin
               step_used = 1'b1;
               if (tick_elapsed(cfg.alarm_ticks)) begin
                  buzz = 1'b0;
                  note(CODE_DONE);
                  begin_entry(PH_CHECK);
                  note(CODE_ENTER);
               end
            end
            default: ;
         endcase
      end else begin
         case (lock_phase)
            PH_WAIT_READY: begin
               if (data == READY_BYTE) begin
                  step_used = 1'b1;
                  begin_entry(PH_SET_FIRST);
                  note(CODE_ENTER);
               end
            end
            PH_SET_FIRST: begin
               step_used = 1'b1;
               if (entry_pos < PW_LEN) entry_buf[entry_pos] = data;
               entry_pos = entry_pos + 1'b1;
               if (entry_pos >= PW_LEN) begin
                  begin_entry(PH_SET_SECOND);
                  note(CODE_REPEAT);
               end
            end
            PH_SET_SECOND: begin
               step_used = 1'b1;
               if (entry_pos < PW_LEN && entry_buf[entry_pos] != data) entry_bad = 1'b1;
               entry_pos = entry_pos + 1'b1;
               if (entry_pos >= PW_LEN) begin
                  if (entry_bad) begin
                     note(CODE_NOMATCH);
                     begin_entry(PH_SET_FIRST);
                     note(CODE_ENTER);
                  end else begin
                     saved_pw = entry_buf;
                     note(CODE_MATCH);
                     if (first_pw) begin
                        first_pw = 1'b0;
                        begin_entry(PH_CHECK);
                        note(CODE_ENTER);
                     end else begin
                        lock_phase = PH_OPTION;
                        note(CODE_OPTION);
                     end
                  end
               end
            end
            PH_CHECK: begin
               step_used = 1'b1;
               if (entry_pos < PW_LEN && saved_pw[entry_pos] != data) entry_bad = 1'b1;
               entry_pos = entry_pos + 1'b1;
               if (entry_pos >= PW_LEN) begin
                  if (!entry_bad) begin
                     fail_cnt = '0;
                     note(CODE_MATCH);
                     lock_phase = PH_OPTION;
                     note(CODE_OPTION);
                  end else begin
                     note(CODE_NOMATCH);
                     fail_cnt = fail_cnt + 1'b1;
                     if (fail_cnt >= cfg.max_failures || fail_cnt == '0) begin
                        fail_cnt   = '0;
                        tick_cnt   = '0;
                        buzz       = 1'b1;
                        lock_phase = PH_ALARM;
                        note(CODE_BUZZER);
                     end else begin
                        begin_entry(PH_CHECK);
                        note(CODE_ENTER);
                     end
                  end
               end
            end
            PH_OPTION: begin
               step_used = 1'b1;
               if (data == OPT_CHANGE) begin
                  begin_entry(PH_SET_FIRST);
                  note(CODE_ENTER);
               end else if (data == OPT_OPEN) begin
                  tick_cnt   = '0;
                  motor      = MOTOR_CW;
                  lock_phase = PH_OPENING;
                  note(CODE_OPEN);
               end else begin
                  note(CODE_OPTION);
               end
            end
            default: ;
         endcase
      end
   endfunction

   // Queues the model's answers for the last request, marking the final one
   function automatic void queue_predicted();
      rsp_item_type item;
      foreach (step_replies[k]) begin
         item      = step_replies[k];
         item.last = (k == step_replies.size() - 1);
         awaited_replies.push_back(item);
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_request(logic cmd, logic [BYTE_W-1:0] data);
      int gap;
      if (requests_sent % 32 == 0) req_steady = ($urandom_range(0, 3) == 0);
      gap = req_steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.cmd     <= cmd;
      req_ch.rx_byte <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic put_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_config(logic [FAIL_W-1:0] max_fail, logic [TICK_W-1:0] open_t,
                             logic [TICK_W-1:0] hold_t, logic [TICK_W-1:0] alarm_t);
      put_register(CSR_MAX_FAILURES, CSR_DATA_W'(max_fail));
      put_register(CSR_OPEN_TICKS, open_t);
      put_register(CSR_HOLD_TICKS, hold_t);
      put_register(CSR_ALARM_TICKS, alarm_t);
      csr_we <= 1'b0;
      cfg = '{max_fail, open_t, hold_t, alarm_t};
      settings_run++;
   endtask

   // Stop sending, wait for every awaited answer, then let the pipeline settle
   task automatic drain_replies();
      req_ch.valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Mostly well-formed traffic for the current phase, with some noise
   task automatic pick_request(output logic cmd, output logic [BYTE_W-1:0] data);
      int r;
      r    = $urandom_range(0, 99);
      cmd  = CMD_BYTE;
      data = BYTE_W'($urandom_range(0, 255));
      case (lock_phase)
         PH_WAIT_READY: begin
            if (r < 75) data = READY_BYTE;
            else if (r < 87) cmd = CMD_TICK;
         end
         PH_SET_FIRST: begin
            if (r < 8) cmd = CMD_TICK;
         end
         PH_SET_SECOND, PH_CHECK: begin
            if (r < 8) begin
               cmd = CMD_TICK;
            end else begin
               if (entry_pos == 0)
                  honest_entry = $urandom_range(0, 99) <
                                 ((lock_phase == PH_SET_SECOND) ? 75 : 50);
               if (honest_entry)
                  data = (lock_phase == PH_SET_SECOND) ? entry_buf[entry_pos]
                                                       : saved_pw[entry_pos];
            end
         end
         PH_OPTION: begin
            if (r < 8) cmd = CMD_TICK;
            else if (r < 48) data = OPT_OPEN;
            else if (r < 73) data = OPT_CHANGE;
         end
         default: begin
            if (r < 93) cmd = CMD_TICK;
         end
      endcase
   endtask

   task automatic run_setting(logic [FAIL_W-1:0] max_fail, logic [TICK_W-1:0] open_t,
                              logic [TICK_W-1:0] hold_t, logic [TICK_W-1:0] alarm_t,
                              int target);
      int            used;
      logic              cmd;
      logic [BYTE_W-1:0] data;
      used = 0;
      drain_replies();
      set_config(max_fail, open_t, hold_t, alarm_t);
      // finish any timed phase so the next setting starts from a byte phase
      while (used < target || lock_phase >= PH_OPENING) begin
         pick_request(cmd, data);
         send_request(cmd, data);
         advance_lock(cmd, data);
         queue_predicted();
         if (step_used) begin
            used++;
            requests_used++;
         end
      end
   endtask

   // ---------------------------------------------------------------- result side

   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (replies_seen % 40 == 0) rsp_steady = ($urandom_range(0, 3) == 0);
         stall = rsp_steady ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // Compare each accepted answer with the oldest awaited one
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.tx_code, rsp_ch.motor_drive, rsp_ch.buzzer, rsp_ch.last};
         replies_seen++;
         if (awaited_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none,", $time,
                     " got code %0d motor %0d buzzer %0b last %0b",
                     got.tx_code, got.motor_drive, got.buzzer, got.last);
         end else begin
            want = awaited_replies.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: result expected code %0d motor %0d buzzer %0b last %0b,",
                        $time, want.tx_code, want.motor_drive, want.buzzer, want.last,
                        " got code %0d motor %0d buzzer %0b last %0b",
                        got.tx_code, got.motor_drive, got.buzzer, got.last);
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("password_lock_controller: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      rsp_item_type item;
      req_ch.valid   = 1'b0;
      req_ch.cmd     = CMD_BYTE;
      req_ch.rx_byte = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_MAX_FAILURES;
      csr_wdata      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      lock_reset();

      // directed: zero failure limit and immediate tick limits
      set_config(4'd0, 10'd0, 10'd1, 10'd0);
      foreach (dir_rows[k]) begin
         send_request(dir_rows[k].cmd, dir_rows[k].data);
         advance_lock(dir_rows[k].cmd, dir_rows[k].data);
         if (step_used) requests_used++;
         if (dir_rows[k].n < 0) begin
            queue_predicted();
         end else begin
            for (int j = 0; j < dir_rows[k].n; j++) begin
               if (j == 0)
                  item = rsp_item_type'{dir_rows[k].c0, dir_rows[k].m0, dir_rows[k].b0, 1'b0};
               else
                  item = rsp_item_type'{dir_rows[k].c1, dir_rows[k].m1, dir_rows[k].b1, 1'b0};
               item.last = (j == dir_rows[k].n - 1);
               awaited_replies.push_back(item);
            end
         end
      end

      // random traffic over several register settings, extremes included
      run_setting(4'd3, 10'd3, 10'd2, 10'd2, 100);
      run_setting(4'd15, 10'd12, 10'd3, 10'd9, 100);
      run_setting(4'd1, 10'd1, 10'd7, 10'd1, 100);
      run_setting(4'd2, 10'd5, 10'd1, 10'd6, 100);
      drain_replies();

      $display("Sent %0d requests (%0d acted on) under %0d register settings;",
               requests_sent, requests_used, settings_run);
      $display("checked %0d results, %0d errors.", replies_seen, errors);
      if (errors == 0) begin
         $display("password_lock_controller: match");
      end else begin
         $display("password_lock_controller: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/plc_pkg.sv
rtl/plc_if.sv
rtl/plc_rsp_fifo.sv
rtl/plc_core.sv
rtl/password_lock_controller.sv
rtl/plc_checker.sv
sim/testbench.sv
